// ===== hw/rtl/dwt_pkg.sv =====
package dwt_pkg;

  localparam int DEF_MAX_SAMPLES = 1024;
  localparam int DEF_MAX_LEVELS  = 10;
  localparam int DEF_COEFF_DEPTH = 2080;
  localparam int TAPS            = 8;

  localparam int SAMPLE_W = 16;
  localparam int RIDX_W   = 12;
  localparam int COEF_W   = 32;
  localparam int TOTAL_W  = 12;
  localparam int LCNT_W   = 4;
  localparam int TAP_W    = 18;
  localparam int PROD_W   = COEF_W + TAP_W;
  localparam int ACC_W    = PROD_W + 4;
  localparam int FRAC_SH  = 17;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_NOT_DONE,
    STAT_RANGE
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESP,
    ST_LVL,
    ST_MAC,
    ST_WRA,
    ST_WRD,
    ST_COPY,
    ST_FIN
  } state_t;

  function automatic logic signed [TAP_W-1:0] lo_tap(input logic [2:0] j);
    logic signed [TAP_W-1:0] t;
    case (j)
      3'd0: t = -18'sd1389;
      3'd1: t = 18'sd4310;
      3'd2: t = 18'sd4042;
      3'd3: t = -18'sd24515;
      3'd4: t = -18'sd3668;
      3'd5: t = 18'sd82691;
      3'd6: t = 18'sd93696;
      3'd7: t = 18'sd30196;
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic signed [TAP_W-1:0] hi_tap(input logic [2:0] j);
    logic signed [TAP_W-1:0] t;
    case (j)
      3'd0: t = 18'sd30196;
      3'd1: t = -18'sd93696;
      3'd2: t = 18'sd82691;
      3'd3: t = 18'sd3668;
      3'd4: t = -18'sd24515;
      3'd5: t = -18'sd4042;
      3'd6: t = 18'sd4310;
      3'd7: t = 18'sd1389;
      default: t = '0;
    endcase
    return t;
  endfunction

  // round half up to Q.8, then saturate to 32 bits
  function automatic logic signed [COEF_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] v;
    logic [ACC_W-FRAC_SH:0] q;
    logic [COEF_W-1:0] r;
    v = {acc[ACC_W-1], acc} + (ACC_W+1)'(65536);
    q = v[ACC_W:FRAC_SH];
    if (&q[ACC_W-FRAC_SH:COEF_W-1] || ~|q[ACC_W-FRAC_SH:COEF_W-1]) begin
      r = q[COEF_W-1:0];
    end else if (q[ACC_W-FRAC_SH]) begin
      r = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COEF_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/dwt_ifs.sv =====
interface dwt_in_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic signed [dwt_pkg::SAMPLE_W-1:0] sample_value;
  logic                              is_last;
  logic [dwt_pkg::RIDX_W-1:0]        read_index;

  modport source (output valid, operation, sample_value, is_last, read_index, input ready);
  modport sink (input valid, operation, sample_value, is_last, read_index, output ready);
endinterface

interface dwt_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [dwt_pkg::COEF_W-1:0]  coefficient;
  logic [1:0]                         status;
  logic [dwt_pkg::TOTAL_W-1:0]        total_count;

  modport source (output valid, coefficient, status, total_count, input ready);
  modport sink (input valid, coefficient, status, total_count, output ready);
endinterface

// ===== hw/rtl/dwt_db4_multilevel_decompose.sv =====
// channel    dir   handshake      payload
// in_item    in    valid/ready    operation, sample_value, is_last, read_index
// out_item   out   valid/ready    coefficient, status, total_count
// cfg        in    cfg_we         cfg_wdata = level_count
//
// A load is written to the work buffer when it is accepted; an accepted read passes
// through the response state before its item is presented from output registers.
// A transform runs on one shared dual multiply-accumulate unit: each output pair
// reads the buffer once per tap, drains the pipeline and writes two store entries;
// each level adds a setup state and a copy back to the work buffer, and a final copy ends it.
// Reset is synchronous, active low; the memories are not cleared.
// Input is not ready while a transform runs, a read response is prepared or an output item waits.
module dwt_db4_multilevel_decompose #(
  parameter int MAX_SAMPLES = dwt_pkg::DEF_MAX_SAMPLES,
  parameter int MAX_LEVELS  = dwt_pkg::DEF_MAX_LEVELS,
  parameter int COEFF_DEPTH = dwt_pkg::DEF_COEFF_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  dwt_in_if.sink                      in_item,
  dwt_out_if.source                   out_item,
  input  logic                        cfg_we,
  input  logic [dwt_pkg::LCNT_W-1:0]  cfg_wdata
);

  localparam int BA_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int SC_W   = $clog2(MAX_SAMPLES + 1);
  localparam int CA_W   = $clog2(COEFF_DEPTH);
  localparam int TOT_W  = $clog2(COEFF_DEPTH + 1);
  localparam int LV_W   = $clog2(MAX_LEVELS + 1);
  localparam int BASE_W = $clog2(2 * MAX_SAMPLES + 2 * MAX_LEVELS + 1) + 1;
  localparam int CW     = dwt_pkg::COEF_W;
  localparam int AW     = dwt_pkg::ACC_W;
  localparam int PW     = dwt_pkg::PROD_W;

  dwt_pkg::state_t state_r, state_nxt;

  logic [dwt_pkg::LCNT_W-1:0] level_count_r;
  logic [SC_W-1:0]   sample_count_r, sample_count_nxt;
  logic              done_r, done_nxt;
  logic [TOT_W-1:0]  stored_total_r, stored_total_nxt;

  logic [SC_W-1:0]   n_r, n_nxt, half_r, half_nxt, i_r, i_nxt, ci_r, ci_nxt;
  logic [BA_W-1:0]   start_r, start_nxt, pos_r, pos_nxt;
  logic [3:0]        j_r, j_nxt;
  logic [LV_W-1:0]   lvl_r, lvl_nxt, levels_r, levels_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;

  logic              v1_r, v1_nxt, v2_r;
  logic [2:0]        jq_r, jq_nxt;
  logic signed [CW-1:0] wb_q_r, st_q_r;
  logic signed [PW-1:0] pa_r, pd_r;
  logic signed [AW-1:0] acc_a_r, acc_a_nxt, acc_d_r, acc_d_nxt;

  logic              cp_v_r, cp_v_nxt, cp_zero_r, cp_zero_nxt;
  logic [BA_W-1:0]   cp_idx_r, cp_idx_nxt;
  logic              fn_v_r, fn_v_nxt;
  logic [BASE_W-1:0] fn_addr_r, fn_addr_nxt;

  dwt_pkg::status_t  rd_status_r, rd_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic signed [CW-1:0] out_coef_r;
  dwt_pkg::status_t  out_status_r;
  logic [dwt_pkg::TOTAL_W-1:0] out_total_r;

  logic signed [CW-1:0] wb_mem [MAX_SAMPLES];
  logic signed [CW-1:0] cs_mem [COEFF_DEPTH];

  logic              wb_we, wb_re, cs_we, cs_re;
  logic [BA_W-1:0]   wb_waddr, wb_raddr;
  logic [CA_W-1:0]   cs_waddr, cs_raddr;
  logic signed [CW-1:0] wb_wdata, cs_wdata;

  logic              in_ready, in_fire;
  logic [SC_W-1:0]   cnt_eff, cnt_new;
  logic [31:0]       ridx_ext;
  logic [BASE_W-1:0] addr_a, addr_d, addr_c, total_sum;
  logic [BA_W-1:0]   start_step;
  logic [SC_W:0]     half_calc;
  logic              last_pair, last_level;

  function automatic logic [BA_W-1:0] wrap_inc(input logic [BA_W-1:0] x,
                                               input logic [SC_W-1:0] n);
    logic [SC_W-1:0] xp;
    xp = SC_W'(x) + SC_W'(1);
    return (xp == n) ? '0 : xp[BA_W-1:0];
  endfunction

  assign in_ready       = (state_r == dwt_pkg::ST_IDLE) && !out_valid_r;
  assign in_fire        = in_item.valid && in_ready;
  assign in_item.ready  = in_ready;

  assign out_item.valid       = out_valid_r;
  assign out_item.coefficient = out_coef_r;
  assign out_item.status      = out_status_r;
  assign out_item.total_count = out_total_r;

  assign cnt_eff    = done_r ? '0 : sample_count_r;
  assign cnt_new    = (32'(cnt_eff) < MAX_SAMPLES) ? cnt_eff + SC_W'(1) : cnt_eff;
  assign ridx_ext   = 32'(in_item.read_index);
  assign addr_a     = base_r + BASE_W'(i_r);
  assign addr_d     = base_r + BASE_W'(half_r) + BASE_W'(i_r);
  assign addr_c     = base_r + BASE_W'(ci_r);
  assign total_sum  = base_r + BASE_W'(n_r);
  assign start_step = wrap_inc(wrap_inc(start_r, n_r), n_r);
  assign half_calc  = ({1'b0, n_r} + (SC_W+1)'(1)) >> 1;
  assign last_pair  = (i_r + SC_W'(1)) == half_r;
  assign last_level = (lvl_r + LV_W'(1)) == levels_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dwt_pkg::ST_IDLE: begin
        if (in_fire && in_item.operation) begin
          state_nxt = dwt_pkg::ST_RESP;
        end else if (in_fire && in_item.is_last) begin
          state_nxt = dwt_pkg::ST_LVL;
        end
      end
      dwt_pkg::ST_RESP: state_nxt = dwt_pkg::ST_IDLE;
      dwt_pkg::ST_LVL:  state_nxt = dwt_pkg::ST_MAC;
      dwt_pkg::ST_MAC: begin
        if (j_r == 4'd8 && !v1_r && !v2_r) state_nxt = dwt_pkg::ST_WRA;
      end
      dwt_pkg::ST_WRA:  state_nxt = dwt_pkg::ST_WRD;
      dwt_pkg::ST_WRD:  state_nxt = last_pair ? dwt_pkg::ST_COPY : dwt_pkg::ST_MAC;
      dwt_pkg::ST_COPY: begin
        if (ci_r == half_r) state_nxt = last_level ? dwt_pkg::ST_FIN : dwt_pkg::ST_LVL;
      end
      dwt_pkg::ST_FIN: begin
        if (ci_r == n_r) state_nxt = dwt_pkg::ST_IDLE;
      end
      default: state_nxt = dwt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sample_count_nxt = sample_count_r;
    done_nxt         = done_r;
    stored_total_nxt = stored_total_r;
    n_nxt      = n_r;
    half_nxt   = half_r;
    i_nxt      = i_r;
    ci_nxt     = ci_r;
    start_nxt  = start_r;
    pos_nxt    = pos_r;
    j_nxt      = j_r;
    lvl_nxt    = lvl_r;
    levels_nxt = levels_r;
    base_nxt   = base_r;
    v1_nxt     = 1'b0;
    jq_nxt     = j_r[2:0];
    acc_a_nxt  = v2_r ? acc_a_r + AW'(pa_r) : acc_a_r;
    acc_d_nxt  = v2_r ? acc_d_r + AW'(pd_r) : acc_d_r;
    cp_v_nxt    = 1'b0;
    cp_zero_nxt = 1'b0;
    cp_idx_nxt  = ci_r[BA_W-1:0];
    fn_v_nxt    = 1'b0;
    fn_addr_nxt = addr_c;
    rd_status_nxt = rd_status_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    wb_we = 1'b0; wb_waddr = '0; wb_wdata = '0; wb_re = 1'b0; wb_raddr = pos_r;
    cs_we = 1'b0; cs_waddr = '0; cs_wdata = '0; cs_re = 1'b0; cs_raddr = '0;

    unique case (state_r)
      dwt_pkg::ST_IDLE: begin
        if (in_fire && !in_item.operation) begin
          done_nxt         = 1'b0;
          sample_count_nxt = cnt_new;
          if (32'(cnt_eff) < MAX_SAMPLES) begin
            wb_we    = 1'b1;
            wb_waddr = cnt_eff[BA_W-1:0];
            wb_wdata = CW'({{(CW-dwt_pkg::SAMPLE_W-8){in_item.sample_value[dwt_pkg::SAMPLE_W-1]}},
                            in_item.sample_value, 8'd0});
          end
          if (in_item.is_last) begin
            n_nxt    = cnt_new;
            lvl_nxt  = '0;
            base_nxt = '0;
            if (level_count_r == '0) begin
              levels_nxt = LV_W'(1);
            end else if (32'(level_count_r) > MAX_LEVELS) begin
              levels_nxt = LV_W'(MAX_LEVELS);
            end else begin
              levels_nxt = LV_W'(level_count_r);
            end
          end
        end else if (in_fire) begin
          if (!done_r) begin
            rd_status_nxt = dwt_pkg::STAT_NOT_DONE;
          end else if (ridx_ext >= 32'(stored_total_r) || ridx_ext >= COEFF_DEPTH) begin
            rd_status_nxt = dwt_pkg::STAT_RANGE;
          end else begin
            rd_status_nxt = dwt_pkg::STAT_OK;
            cs_re    = 1'b1;
            cs_raddr = ridx_ext[CA_W-1:0];
          end
        end
      end
      dwt_pkg::ST_RESP: out_valid_nxt = 1'b1;
      dwt_pkg::ST_LVL: begin
        half_nxt = half_calc[SC_W-1:0];
        i_nxt    = '0;
        j_nxt    = '0;
        if (n_r >= SC_W'(3)) begin
          start_nxt = BA_W'(n_r - SC_W'(3));
        end else if (n_r == SC_W'(2)) begin
          start_nxt = BA_W'(1);
        end else begin
          start_nxt = '0;
        end
        pos_nxt = start_nxt;
      end
      dwt_pkg::ST_MAC: begin
        if (j_r == '0) begin
          acc_a_nxt = '0;
          acc_d_nxt = '0;
        end
        if (j_r < 4'd8) begin
          wb_re    = 1'b1;
          wb_raddr = pos_r;
          pos_nxt  = wrap_inc(pos_r, n_r);
          j_nxt    = j_r + 4'd1;
          v1_nxt   = 1'b1;
        end
      end
      dwt_pkg::ST_WRA: begin
        if (32'(addr_a) < COEFF_DEPTH) begin
          cs_we    = 1'b1;
          cs_waddr = addr_a[CA_W-1:0];
          cs_wdata = dwt_pkg::round_sat(acc_a_r);
        end
      end
      dwt_pkg::ST_WRD: begin
        if (32'(addr_d) < COEFF_DEPTH) begin
          cs_we    = 1'b1;
          cs_waddr = addr_d[CA_W-1:0];
          cs_wdata = dwt_pkg::round_sat(acc_d_r);
        end
        if (last_pair) begin
          ci_nxt = '0;
        end else begin
          i_nxt     = i_r + SC_W'(1);
          start_nxt = start_step;
          pos_nxt   = start_step;
          j_nxt     = '0;
        end
      end
      dwt_pkg::ST_COPY: begin
        if (cp_v_r) begin
          wb_we    = 1'b1;
          wb_waddr = cp_idx_r;
          wb_wdata = cp_zero_r ? '0 : st_q_r;
        end
        if (ci_r != half_r) begin
          cp_v_nxt    = 1'b1;
          cp_zero_nxt = !(32'(addr_c) < COEFF_DEPTH);
          cs_re       = !cp_zero_nxt;
          cs_raddr    = addr_c[CA_W-1:0];
          ci_nxt      = ci_r + SC_W'(1);
        end else begin
          base_nxt = base_r + BASE_W'(half_r) + BASE_W'(half_r);
          n_nxt    = half_r;
          lvl_nxt  = lvl_r + LV_W'(1);
          ci_nxt   = '0;
        end
      end
      dwt_pkg::ST_FIN: begin
        if (fn_v_r && 32'(fn_addr_r) < COEFF_DEPTH) begin
          cs_we    = 1'b1;
          cs_waddr = fn_addr_r[CA_W-1:0];
          cs_wdata = wb_q_r;
        end
        if (ci_r != n_r) begin
          wb_re    = 1'b1;
          wb_raddr = ci_r[BA_W-1:0];
          fn_v_nxt = 1'b1;
          ci_nxt   = ci_r + SC_W'(1);
        end else begin
          done_nxt = 1'b1;
          stored_total_nxt = (32'(total_sum) > COEFF_DEPTH) ? TOT_W'(COEFF_DEPTH)
                                                            : TOT_W'(total_sum);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wb_we) wb_mem[wb_waddr] <= wb_wdata;
    if (wb_re) wb_q_r <= wb_mem[wb_raddr];
  end

  always_ff @(posedge clk) begin
    if (cs_we) cs_mem[cs_waddr] <= cs_wdata;
    if (cs_re) st_q_r <= cs_mem[cs_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= dwt_pkg::ST_IDLE;
      level_count_r  <= dwt_pkg::LCNT_W'(1);
      sample_count_r <= '0;
      done_r         <= 1'b0;
      stored_total_r <= '0;
      v1_r           <= 1'b0;
      v2_r           <= 1'b0;
      cp_v_r         <= 1'b0;
      fn_v_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      if (cfg_we) level_count_r <= cfg_wdata;
      sample_count_r <= sample_count_nxt;
      done_r         <= done_nxt;
      stored_total_r <= stored_total_nxt;
      v1_r           <= v1_nxt;
      v2_r           <= v1_r;
      cp_v_r         <= cp_v_nxt;
      fn_v_r         <= fn_v_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    half_r    <= half_nxt;
    i_r       <= i_nxt;
    ci_r      <= ci_nxt;
    start_r   <= start_nxt;
    pos_r     <= pos_nxt;
    j_r       <= j_nxt;
    lvl_r     <= lvl_nxt;
    levels_r  <= levels_nxt;
    base_r    <= base_nxt;
    jq_r      <= jq_nxt;
    pa_r      <= wb_q_r * dwt_pkg::lo_tap(jq_r);
    pd_r      <= wb_q_r * dwt_pkg::hi_tap(jq_r);
    acc_a_r   <= acc_a_nxt;
    acc_d_r   <= acc_d_nxt;
    cp_zero_r <= cp_zero_nxt;
    cp_idx_r  <= cp_idx_nxt;
    fn_addr_r <= fn_addr_nxt;
    rd_status_r <= rd_status_nxt;
    if (state_r == dwt_pkg::ST_RESP) begin
      out_status_r <= rd_status_r;
      out_coef_r   <= (rd_status_r == dwt_pkg::STAT_OK) ? st_q_r : '0;
      out_total_r  <= dwt_pkg::TOTAL_W'(stored_total_r);
    end
  end

  a_resp_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dwt_pkg::ST_RESP |=> out_valid_r)
    else $error("read item not presented");

  a_done_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(state_r) == dwt_pkg::ST_FIN)
    else $error("transform marked done outside final copy");

  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dwt_pkg::ST_MAC && j_r == '0) |-> !v2_r && !v1_r)
    else $error("accumulator cleared while products in flight");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(stored_total_r) <= COEFF_DEPTH)
    else $error("stored total exceeds store depth");

endmodule
